FILE: rtl/core/cbp_pkg.sv
`default_nettype none

package cbp_pkg;

   // Default sizing of the counter table index.
   localparam int MAX_PC_BITS_DEF      = 8;
   localparam int MAX_HISTORY_BITS_DEF = 4;

   // Field widths of the channels.
   localparam int ADDR_W  = 24;
   localparam int TOTAL_W = 32;
   localparam int CTR_W   = 2;

   // Configuration register widths and reset values.
   localparam int HIST_CFG_W = 3;
   localparam int CTR_CFG_W  = 2;
   localparam int PC_CFG_W   = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [HIST_CFG_W-1:0] HIST_CFG_RESET = 3'd0;
   localparam logic [CTR_CFG_W-1:0]  CTR_CFG_RESET  = 2'd2;
   localparam logic [PC_CFG_W-1:0]   PC_CFG_RESET   = 4'd6;

   // Register indexes on the configuration port (word address).
   localparam logic [1:0] REG_HISTORY_BITS = 2'd0;
   localparam logic [1:0] REG_COUNTER_BITS = 2'd1;
   localparam logic [1:0] REG_PC_BITS      = 2'd2;

   // Counter mode code that selects the one-bit last-outcome scheme.
   localparam logic [CTR_CFG_W-1:0] COUNTER_MODE_ONE = 2'd1;

   // Counter states.
   localparam logic [CTR_W-1:0] CTR_SNT = 2'd0;
   localparam logic [CTR_W-1:0] CTR_WNT = 2'd1;
   localparam logic [CTR_W-1:0] CTR_WT  = 2'd2;
   localparam logic [CTR_W-1:0] CTR_ST  = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // Next counter value after a resolved branch.
   function automatic logic [CTR_W-1:0] train_counter(
      input logic [CTR_W-1:0] cur,
      input logic             taken,
      input logic             one_bit
   );
      logic [CTR_W-1:0] nxt;
      if (one_bit) begin
         nxt = taken ? CTR_ST : CTR_SNT;
      end else if (taken) begin
         nxt = (cur == CTR_SNT) ? CTR_WNT : CTR_ST;
      end else begin
         nxt = (cur == CTR_ST) ? CTR_WT : CTR_SNT;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbp_req_if.sv
`default_nettype none

interface cbp_req_if;
   logic                         valid;
   logic                         ready;
   logic [cbp_pkg::ADDR_W-1:0]   branch_address;
   logic                         taken;

   modport source (output valid, output branch_address, output taken, input ready);
   modport sink (input valid, input branch_address, input taken, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cbp_rsp_if.sv
`default_nettype none

interface cbp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         predicted_taken;
   logic                         mispredicted;
   logic [cbp_pkg::TOTAL_W-1:0]  hit_total;
   logic [cbp_pkg::TOTAL_W-1:0]  branch_total;

   modport source (output valid, output predicted_taken, output mispredicted,
                   output hit_total, output branch_total, input ready);
   modport sink (input valid, input predicted_taken, input mispredicted,
                 input hit_total, input branch_total, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/correlating_branch_predictor.sv
// Correlating branch predictor.
// Each word on the req channel is a resolved branch (address and taken bit).
// The block indexes a table of counters with the low pc_bits of the address
// joined above the low history_bits of the global history, predicts from the
// counter, trains it and shifts the outcome into the history. Each req word
// yields exactly one rsp word carrying the prediction, the miss flag and the
// saturating hit and branch totals including this branch.
// An accepted word's counter is read on accept, then trained and written back
// in the lookup state as the result is registered onto rsp; no new branch is
// taken until that read-modify-write is through. The rsp output is registered,
// so a new branch is accepted while a result still waits; if rsp stays stalled
// the lookup holds until the result moves. Reset clears history, totals and
// configuration; a clearing pass then sets all 2^(MAX_PC_BITS+MAX_HISTORY_BITS)
// counters (4096 by default) to strongly not taken, with req.ready held low.
// Configuration is written through the csr_ APB port at byte addresses 0
// (history_bits), 4 (counter_bits) and 8 (pc_bits); the user must write it
// only while idle, as the block itself does not enforce this.
`default_nettype none

module correlating_branch_predictor #(
   parameter int MAX_PC_BITS      = cbp_pkg::MAX_PC_BITS_DEF,
   parameter int MAX_HISTORY_BITS = cbp_pkg::MAX_HISTORY_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   cbp_req_if.sink                              req,
   cbp_rsp_if.source                            rsp,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cbp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [cbp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [cbp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                            csr_pready
);

   localparam int IDX_W  = MAX_PC_BITS + MAX_HISTORY_BITS;
   localparam int DEPTH  = 1 << IDX_W;
   localparam int HIST_W = (MAX_HISTORY_BITS > 0) ? MAX_HISTORY_BITS : 1;

   cbp_pkg::state_type state_ff, state_in;

   logic [cbp_pkg::HIST_CFG_W-1:0] hist_cfg_ff;
   logic [cbp_pkg::CTR_CFG_W-1:0]  ctr_cfg_ff;
   logic [cbp_pkg::PC_CFG_W-1:0]   pc_cfg_ff;

   logic [IDX_W-1:0]            clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        taken_ff, taken_in;
   logic [HIST_W-1:0]           hist_ff, hist_in;
   logic [cbp_pkg::TOTAL_W-1:0] hit_ff, hit_in;
   logic [cbp_pkg::TOTAL_W-1:0] branch_ff, branch_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        pred_ff, pred_in;
   logic                        miss_ff, miss_in;

   logic [cbp_pkg::HIST_CFG_W-1:0] hb;
   logic [cbp_pkg::PC_CFG_W-1:0]   pb;
   logic [HIST_W-1:0]              hist_mask;
   logic [MAX_PC_BITS-1:0]         pc_mask;
   logic [IDX_W-1:0]               lookup_idx;

   logic                      accept;
   logic                      advance;
   logic                      csr_write;
   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   logic [cbp_pkg::CTR_W-1:0] ram_wdata;
   logic [cbp_pkg::CTR_W-1:0] ram_rdata;
   logic                      pred;
   logic [cbp_pkg::CTR_W-1:0] new_ctr;

   // Handshakes.
   assign accept    = req.valid && req.ready;
   assign advance   = (state_ff == cbp_pkg::ST_LOOKUP) && (!rsp_valid_ff || rsp.ready);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_cfg_ff <= cbp_pkg::HIST_CFG_RESET;
         ctr_cfg_ff  <= cbp_pkg::CTR_CFG_RESET;
         pc_cfg_ff   <= cbp_pkg::PC_CFG_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            cbp_pkg::REG_HISTORY_BITS: hist_cfg_ff <= csr_pwdata[cbp_pkg::HIST_CFG_W-1:0];
            cbp_pkg::REG_COUNTER_BITS: ctr_cfg_ff  <= csr_pwdata[cbp_pkg::CTR_CFG_W-1:0];
            cbp_pkg::REG_PC_BITS:      pc_cfg_ff   <= csr_pwdata[cbp_pkg::PC_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[3:2])
         cbp_pkg::REG_HISTORY_BITS: csr_prdata = cbp_pkg::CSR_DATA_W'(hist_cfg_ff);
         cbp_pkg::REG_COUNTER_BITS: csr_prdata = cbp_pkg::CSR_DATA_W'(ctr_cfg_ff);
         cbp_pkg::REG_PC_BITS:      csr_prdata = cbp_pkg::CSR_DATA_W'(pc_cfg_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // Field sizes clamp to MAX_HISTORY_BITS and MAX_PC_BITS.
   always_comb begin
      hb = hist_cfg_ff;
      if (int'(hist_cfg_ff) > MAX_HISTORY_BITS) begin
         hb = cbp_pkg::HIST_CFG_W'(MAX_HISTORY_BITS);
      end
      pb = pc_cfg_ff;
      if (int'(pc_cfg_ff) > MAX_PC_BITS) begin
         pb = cbp_pkg::PC_CFG_W'(MAX_PC_BITS);
      end
   end

   // Masks for the active history and address bits.
   always_comb begin
      for (int i = 0; i < HIST_W; i++) begin
         hist_mask[i] = (i < int'(hb));
      end
      for (int i = 0; i < MAX_PC_BITS; i++) begin
         pc_mask[i] = (i < int'(pb));
      end
   end

   // Table index: address bits above the history bits.
   assign lookup_idx = (IDX_W'(req.branch_address[MAX_PC_BITS-1:0] & pc_mask) << hb)
                     | IDX_W'(hist_ff & hist_mask);

   // Prediction and training from the entry read in the lookup cycle.
   assign pred    = ram_rdata[1];
   assign new_ctr = cbp_pkg::train_counter(ram_rdata, taken_ff,
                                           ctr_cfg_ff == cbp_pkg::COUNTER_MODE_ONE);

   // Memory write port: clearing pass or counter write-back.
   always_comb begin
      if (state_ff == cbp_pkg::ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = cbp_pkg::CTR_SNT;
      end else begin
         ram_we    = advance;
         ram_waddr = idx_ff;
         ram_wdata = new_ctr;
      end
   end

   cbp_ram #(
      .WIDTH (cbp_pkg::CTR_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (lookup_idx),
      .rdata (ram_rdata)
   );

   // Sequencer: next state, datapath updates and result register.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      idx_in       = idx_ff;
      taken_in     = taken_ff;
      hist_in      = hist_ff;
      hit_in       = hit_ff;
      branch_in    = branch_ff;
      pred_in      = pred_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      unique case (state_ff)
         cbp_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = cbp_pkg::ST_IDLE;
            end
         end
         cbp_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in   = lookup_idx;
               taken_in = req.taken;
               state_in = cbp_pkg::ST_LOOKUP;
            end
         end
         cbp_pkg::ST_LOOKUP: begin
            if (advance) begin
               if ((pred == taken_ff) && (hit_ff != '1)) begin
                  hit_in = hit_ff + 1'b1;
               end
               if (branch_ff != '1) begin
                  branch_in = branch_ff + 1'b1;
               end
               hist_in      = HIST_W'({hist_ff, taken_ff});
               pred_in      = pred;
               miss_in      = pred != taken_ff;
               rsp_valid_in = 1'b1;
               state_in     = cbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbp_pkg::ST_CLEAR;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbp_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         hist_ff      <= '0;
         hit_ff       <= '0;
         branch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         hist_ff      <= hist_in;
         hit_ff       <= hit_in;
         branch_ff    <= branch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      taken_ff <= taken_in;
      pred_ff  <= pred_in;
      miss_ff  <= miss_in;
   end

   // Channel outputs.
   assign req.ready           = (state_ff == cbp_pkg::ST_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.predicted_taken = pred_ff;
   assign rsp.mispredicted    = miss_ff;
   assign rsp.hit_total       = hit_ff;
   assign rsp.branch_total    = branch_ff;

`ifndef NO_ASSERTIONS
   // No branch enters while the table is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbp_pkg::ST_CLEAR) |-> !accept)
      else $error("branch accepted during clearing pass");

   // An accepted branch always moves on to the lookup cycle.
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == cbp_pkg::ST_LOOKUP))
      else $error("accepted branch did not start a lookup");

   // Each delivered result counts exactly one branch.
   a_branch_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> ((branch_ff == $past(branch_ff) + 1'b1) || ($past(branch_ff) == '1)))
      else $error("branch total did not advance by one");

   // Hits never outnumber branches.
   a_hits_bounded: assert property (@(posedge clock) disable iff (reset)
      hit_ff <= branch_ff)
      else $error("hit total exceeds branch total");

   // A pending result is never overwritten by a new lookup.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready && (state_ff == cbp_pkg::ST_LOOKUP))
      |=> (state_ff == cbp_pkg::ST_LOOKUP))
      else $error("lookup finished while result was stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/cbp_ram.sv
`default_nettype none

module cbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

FILE: test/correlating_branch_predictor_test.sv
`timescale 1ns / 1ps

module correlating_branch_predictor_test;
   import cbp_pkg::*;

   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          TABLE_DEPTH   = 1 << (MAX_PC_BITS_DEF + MAX_HISTORY_BITS_DEF);
   // Address slot just past the last register; writes there must change nothing.
   localparam logic [1:0]  REG_SPARE     = 2'd3;

   typedef struct packed {
      logic               predicted;
      logic               missed;
      logic [TOTAL_W-1:0] hits;
      logic [TOTAL_W-1:0] branches;
   } branch_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cbp_req_if req_if ();
   cbp_rsp_if rsp_if ();

   correlating_branch_predictor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if.sink),
      .rsp         (rsp_if.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state: counter table, global history, totals and settings.
   logic [CTR_W-1:0]                ctr_table [TABLE_DEPTH];
   logic [MAX_HISTORY_BITS_DEF-1:0] global_hist;
   logic [TOTAL_W-1:0]              hit_tally;
   logic [TOTAL_W-1:0]              branch_tally;
   logic [HIST_CFG_W-1:0]           hist_setting;
   logic [CTR_CFG_W-1:0]            ctr_setting;
   logic [PC_CFG_W-1:0]             pc_setting;

   branch_outcome_type expected_outcomes [$];
   branch_outcome_type oldest_outcome;
   int unsigned        mismatch_count;
   int unsigned        cycle_count;
   int unsigned        gap_pct;
   int unsigned        stall_pct;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Runaway guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Works out the result of one resolved branch and trains the table.
   function automatic branch_outcome_type predict_branch(input logic [ADDR_W-1:0] addr,
                                                         input logic taken);
      branch_outcome_type outcome;
      int unsigned        hist_used;
      int unsigned        pc_used;
      int unsigned        slot;
      logic [CTR_W-1:0]   cur;
      logic [CTR_W-1:0]   nxt;
      hist_used = (hist_setting > MAX_HISTORY_BITS_DEF) ? MAX_HISTORY_BITS_DEF : hist_setting;
      pc_used   = (pc_setting > MAX_PC_BITS_DEF) ? MAX_PC_BITS_DEF : pc_setting;
      slot = ((int'(addr) & ((1 << pc_used) - 1)) << hist_used)
           | (int'(global_hist) & ((1 << hist_used) - 1));
      slot = slot & (TABLE_DEPTH - 1);
      cur  = ctr_table[slot];

      outcome.predicted = cur[1];
      outcome.missed    = cur[1] ^ taken;
      if (!outcome.missed && hit_tally != '1) begin
         hit_tally = hit_tally + 1;
      end
      if (branch_tally != '1) begin
         branch_tally = branch_tally + 1;
      end
      outcome.hits     = hit_tally;
      outcome.branches = branch_tally;

      // Last-outcome mode stores the outcome in both bits; any other mode is hysteresis.
      if (ctr_setting == COUNTER_MODE_ONE) begin
         nxt = taken ? CTR_ST : CTR_SNT;
      end else begin
         case (cur)
            CTR_SNT: nxt = taken ? CTR_WNT : CTR_SNT;
            CTR_ST:  nxt = taken ? CTR_ST : CTR_WT;
            default: nxt = taken ? CTR_ST : CTR_SNT;
         endcase
      end
      ctr_table[slot] = nxt;
      global_hist = {global_hist[MAX_HISTORY_BITS_DEF-2:0], taken};
      return outcome;
   endfunction

   // Sends one branch word, with an optional idle burst ahead of it.
   task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
      branch_outcome_type outcome;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.branch_address <= addr;
      req_if.taken          <= taken;
      do @(posedge clock); while (!req_if.ready);
      outcome = predict_branch(addr, taken);
      expected_outcomes.insert(expected_outcomes.size(), outcome);
   endtask

   // Drops valid and waits until every expected word has come back.
   task automatic wait_for_quiet();
      req_if.valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] word;
      // Upper bits carry junk that the register must drop.
      word = value | (32'($urandom()) << PC_CFG_W);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_HISTORY_BITS: hist_setting = word[HIST_CFG_W-1:0];
         REG_COUNTER_BITS: ctr_setting  = word[CTR_CFG_W-1:0];
         REG_PC_BITS:      pc_setting   = word[PC_CFG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int unsigned hist, input int unsigned mode,
                                 input int unsigned pc);
      wait_for_quiet();
      csr_write(REG_HISTORY_BITS, hist);
      csr_write(REG_COUNTER_BITS, mode);
      csr_write(REG_PC_BITS, pc);
   endtask

   // Mostly loop-shaped branches from a few hot addresses, plus some noise.
   task automatic run_branch_stream(input int unsigned count);
      logic [ADDR_W-1:0] loop_pc [6];
      int unsigned       loop_len [6];
      int unsigned       loop_pos [6];
      int unsigned       pick;
      int unsigned       roll;
      logic [ADDR_W-1:0] addr;
      logic              taken;
      for (int i = 0; i < 6; i++) begin
         loop_pc[i]  = ADDR_W'($urandom());
         loop_len[i] = $urandom_range(2, 6);
         loop_pos[i] = 0;
      end
      repeat (count) begin
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, 5);
         if (roll < 70) begin
            addr  = loop_pc[pick];
            taken = (loop_pos[pick] != loop_len[pick] - 1);
            loop_pos[pick] = (loop_pos[pick] + 1) % loop_len[pick];
         end else if (roll < 85) begin
            addr  = loop_pc[pick];
            taken = 1'($urandom_range(0, 1));
         end else begin
            addr  = ADDR_W'($urandom());
            taken = 1'($urandom_range(0, 1));
         end
         send_branch(addr, taken);
      end
   endtask

   // Reset settings: walk one counter through every transition, then address extremes.
   task automatic test_reset_defaults();
      gap_pct   = 25;
      stall_pct = 20;
      send_branch(24'h000000, 1'b0);
      send_branch(24'h000000, 1'b1);
      send_branch(24'h000000, 1'b0);
      send_branch(24'h000000, 1'b1);
      send_branch(24'h000000, 1'b1);
      send_branch(24'h000000, 1'b1);
      send_branch(24'h000000, 1'b1);
      send_branch(24'h000000, 1'b0);
      send_branch(24'h000000, 1'b1);
      send_branch(24'h000000, 1'b0);
      send_branch(24'h000000, 1'b0);
      send_branch(24'hFFFFFF, 1'b1);
      send_branch(24'hFFFFFF, 1'b1);
      send_branch(24'hFFFFC0, 1'b1);
      send_branch(24'hAAAAAA, 1'b0);
      send_branch(24'h555555, 1'b1);
      run_branch_stream(150);
   endtask

   // Full history and address width with hysteresis counters.
   task automatic test_history_correlation();
      apply_settings(MAX_HISTORY_BITS_DEF, 2, MAX_PC_BITS_DEF);
      gap_pct   = 0;
      stall_pct = 0;
      run_branch_stream(120);
      gap_pct   = 30;
      stall_pct = 30;
      run_branch_stream(130);
   endtask

   task automatic test_one_bit_mode();
      apply_settings(2, COUNTER_MODE_ONE, 4);
      gap_pct   = 15;
      stall_pct = 35;
      send_branch(24'h000013, 1'b1);
      send_branch(24'h000013, 1'b1);
      send_branch(24'h000013, 1'b0);
      run_branch_stream(200);
   endtask

   // No address bits: only the history picks the entry; mode 0 acts as hysteresis.
   task automatic test_no_address_bits();
      apply_settings(3, 0, 0);
      gap_pct   = 35;
      stall_pct = 10;
      send_branch(24'h123456, 1'b1);
      send_branch(24'hFEDCBA, 1'b1);
      send_branch(24'h000001, 1'b0);
      run_branch_stream(150);
   endtask

   // Field values past the table limits saturate; mode 3 acts as hysteresis.
   task automatic test_oversized_fields();
      apply_settings(7, 3, 15);
      gap_pct   = 20;
      stall_pct = 20;
      run_branch_stream(150);
   endtask

   task automatic test_spare_register();
      apply_settings(1, 2, 8);
      csr_write(REG_SPARE, $urandom_range(0, 15));
      gap_pct   = 10;
      stall_pct = 40;
      run_branch_stream(100);
   endtask

   // Settings drawn over the whole register ranges.
   task automatic test_random_settings();
      repeat (4) begin
         apply_settings($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 15));
         gap_pct   = $urandom_range(0, 40);
         stall_pct = $urandom_range(0, 40);
         run_branch_stream(80);
      end
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_full_rate();
      apply_settings(4, 1, 1);
      gap_pct   = 0;
      stall_pct = 0;
      run_branch_stream(150);
   endtask

   // Result side: random ready stalls.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // Each accepted result word is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_outcomes.size() == 0) begin
            $error("result word with no branch outstanding");
            mismatch_count++;
         end else begin
            oldest_outcome = expected_outcomes.pop_front();
            if (rsp_if.predicted_taken !== oldest_outcome.predicted) begin
               $error("predicted_taken: expected %0d, got %0d",
                      oldest_outcome.predicted, rsp_if.predicted_taken);
               mismatch_count++;
            end
            if (rsp_if.mispredicted !== oldest_outcome.missed) begin
               $error("mispredicted: expected %0d, got %0d",
                      oldest_outcome.missed, rsp_if.mispredicted);
               mismatch_count++;
            end
            if (rsp_if.hit_total !== oldest_outcome.hits) begin
               $error("hit_total: expected %0d, got %0d",
                      oldest_outcome.hits, rsp_if.hit_total);
               mismatch_count++;
            end
            if (rsp_if.branch_total !== oldest_outcome.branches) begin
               $error("branch_total: expected %0d, got %0d",
                      oldest_outcome.branches, rsp_if.branch_total);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.branch_address <= '0;
      req_if.taken          <= 1'b0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      cycle_count    = 0;
      mismatch_count = 0;
      gap_pct        = 0;
      stall_pct      = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         ctr_table[i] = CTR_SNT;
      end
      global_hist  = '0;
      hit_tally    = '0;
      branch_tally = '0;
      hist_setting = HIST_CFG_RESET;
      ctr_setting  = CTR_CFG_RESET;
      pc_setting   = PC_CFG_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_history_correlation();
      test_one_bit_mode();
      test_no_address_bits();
      test_oversized_fields();
      test_spare_register();
      test_random_settings();
      test_full_rate();
      wait_for_quiet();

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: correlating_branch_predictor.f
rtl/core/cbp_pkg.sv
rtl/core/cbp_req_if.sv
rtl/core/cbp_rsp_if.sv
rtl/core/cbp_ram.sv
rtl/core/correlating_branch_predictor.sv
test/correlating_branch_predictor_test.sv
